// File: sv/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg: shared types and constants for the Playfair digraph stream core
// Byte classes, key square reset values, register indexes and the job beat
// passed from the pairing stage to the output stage.
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam int SIDE      = 5;
    localparam int CELL_W    = 5;
    localparam int NCELLS    = SIDE * SIDE;
    localparam int SQUARE_W  = NCELLS * CELL_W;
    localparam int SQ0_W     = 45;
    localparam int SQ1_W     = 40;
    localparam int SQ2_W     = 40;
    localparam int CFG_DW    = 45;

    // Configuration register indexes
    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_SQ0  = 2'd1;
    localparam logic [1:0] CFG_SQ1  = 2'd2;
    localparam logic [1:0] CFG_SQ2  = 2'd3;

    // Identity square at reset: cell n holds n
    localparam logic [SQ0_W-1:0] SQ0_RESET = 45'd9043225708576;
    localparam logic [SQ1_W-1:0] SQ1_RESET = 40'd566345739593;
    localparam logic [SQ2_W-1:0] SQ2_RESET = 40'd850090675793;

    // Input kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOS  = 1'b1;

    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UI = 8'h49;
    localparam logic [7:0] CH_UJ = 8'h4A;
    localparam logic [7:0] CH_UZ = 8'h5A;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LI = 8'h69;
    localparam logic [7:0] CH_LJ = 8'h6A;
    localparam logic [7:0] CH_LZ = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // Work handed from the pairing stage to the output stage
    typedef struct packed {
        logic       valid;
        logic       pair;   // b0/b1 are a letter pair to substitute
        logic [1:0] cnt;    // number of result beats, 1 or 2
        logic [7:0] b0;
        logic [7:0] b1;
    } job_t;

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= CH_UA) && (c <= CH_UZ);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return is_upper(c) || ((c >= CH_LA) && (c <= CH_LZ));
    endfunction

    // J-less alphabet index of a letter (J already folded to I)
    function automatic logic [CELL_W-1:0] alpha_index(input logic [7:0] c);
        logic [7:0] u;
        logic [7:0] d;
        u = is_upper(c) ? c : (c - CASE_OFS);
        d = (u < CH_UJ) ? (u - CH_UA) : (u - CH_UA - 8'd1);
        return d[CELL_W-1:0];
    endfunction

    // Letter for a cell value; out-of-range values give Z
    function automatic logic [7:0] letter_of(input logic [CELL_W-1:0] v, input logic upper);
        logic [7:0] ch;
        if (v < 5'd9)
            ch = CH_UA + {3'd0, v};
        else if (v < 5'd25)
            ch = CH_UA + {3'd0, v} + 8'd1;
        else
            ch = CH_UZ;
        return upper ? ch : (ch + CASE_OFS);
    endfunction

endpackage

// File: sv/pfc_in_stage.sv
// ----------------------------------------------------------------------------
// pfc_in_stage: input pairing and job register
// Classifies each input beat, keeps the unpaired letter and registers the
// resulting job (flush, pass-through or letter pair) for the output stage.
// ----------------------------------------------------------------------------
module pfc_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] data_byte
    input  logic          s_tuser,   // [0] kind
    input  logic          job_take,
    output pfc_pkg::job_t job
);
    import pfc_pkg::*;

    logic       pend_valid_reg, pend_valid_next;
    logic [7:0] pend_letter_reg, pend_letter_next;
    job_t       job_reg, job_next;
    job_t       new_job;
    logic       accept;
    logic [7:0] folded;

    assign s_tready = !job_reg.valid || job_take;
    assign accept   = s_tvalid && s_tready;
    assign job      = job_reg;

    // J/j folds to I/i
    always_comb
    begin
        if (s_tdata == CH_UJ)
            folded = CH_UI;
        else if (s_tdata == CH_LJ)
            folded = CH_LI;
        else
            folded = s_tdata;
    end

    // Beat classification
    always_comb
    begin
        new_job          = '0;
        pend_valid_next  = pend_valid_reg;
        pend_letter_next = pend_letter_reg;
        if (s_tuser == KIND_EOS) begin
            if (pend_valid_reg) begin
                new_job.valid = 1'b1;
                new_job.cnt   = 2'd1;
                new_job.b0    = pend_letter_reg;
            end
            pend_valid_next = 1'b0;
        end else if (!is_letter(s_tdata)) begin
            new_job.valid = 1'b1;
            if (pend_valid_reg) begin
                new_job.cnt = 2'd2;
                new_job.b0  = pend_letter_reg;
                new_job.b1  = s_tdata;
            end else begin
                new_job.cnt = 2'd1;
                new_job.b0  = s_tdata;
            end
            pend_valid_next = 1'b0;
        end else if (!pend_valid_reg) begin
            pend_valid_next  = 1'b1;
            pend_letter_next = folded;
        end else begin
            new_job.valid   = 1'b1;
            new_job.pair    = 1'b1;
            new_job.cnt     = 2'd2;
            new_job.b0      = pend_letter_reg;
            new_job.b1      = folded;
            pend_valid_next = 1'b0;
        end
    end

    // Job register update
    always_comb
    begin
        job_next = job_reg;
        if (job_take)
            job_next.valid = 1'b0;
        if (accept)
            job_next = new_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pend_valid_reg  <= 1'b0;
            pend_letter_reg <= '0;
            job_reg         <= '0;
        end else begin
            job_reg <= job_next;
            if (accept) begin
                pend_valid_reg  <= pend_valid_next;
                pend_letter_reg <= pend_letter_next;
            end
        end
    end

    // A job that is not taken holds unchanged
    ast_job_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (job_reg.valid && !job_take) |=> (job_reg.valid && $stable(job_reg)))
        else $error("job lost or changed while waiting");

    // A pending letter is always a letter
    ast_pend_letter: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> is_letter(pend_letter_reg))
        else $error("pending byte is not a letter");

    // A job only carries a pair of two beats
    ast_pair_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (job_reg.valid && job_reg.pair) |-> (job_reg.cnt == 2'd2))
        else $error("pair job with wrong beat count");

endmodule

// File: sv/pfc_pair_sub.sv
// ----------------------------------------------------------------------------
// pfc_pair_sub: Playfair digraph substitution
// Locates both letters in the key square and applies the row, column or
// rectangle rule; a letter absent from the square leaves the pair unchanged.
// ----------------------------------------------------------------------------
module pfc_pair_sub (
    input  logic [pfc_pkg::SQUARE_W-1:0] square,
    input  logic                         decrypt,
    input  logic [7:0]                   a,
    input  logic [7:0]                   b,
    output logic [7:0]                   ra,
    output logic [7:0]                   rb
);
    import pfc_pkg::*;

    logic [CELL_W-1:0] ia, ib;
    logic              fa, fb;
    logic [2:0]        ar, ac, br, bc;
    logic [2:0]        nar, nac, nbr, nbc;
    logic [CELL_W-1:0] va, vb;

    assign ia = alpha_index(a);
    assign ib = alpha_index(b);

    // Search, highest cell first so the lowest match wins
    always_comb
    begin
        fa = 1'b0; fb = 1'b0;
        ar = '0; ac = '0; br = '0; bc = '0;
        for (int r = SIDE - 1; r >= 0; r--) begin
            for (int c = SIDE - 1; c >= 0; c--) begin
                if (square[(r*SIDE+c)*CELL_W +: CELL_W] == ia) begin
                    fa = 1'b1; ar = 3'(r); ac = 3'(c);
                end
                if (square[(r*SIDE+c)*CELL_W +: CELL_W] == ib) begin
                    fb = 1'b1; br = 3'(r); bc = 3'(c);
                end
            end
        end
    end

    function automatic logic [2:0] step(input logic [2:0] x, input logic back);
        if (back)
            return (x == 3'd0) ? 3'(SIDE - 1) : (x - 3'd1);
        return (x == 3'(SIDE - 1)) ? 3'd0 : (x + 3'd1);
    endfunction

    // Target cell positions
    always_comb
    begin
        if (ar == br) begin
            nar = ar; nac = step(ac, decrypt);
            nbr = br; nbc = step(bc, decrypt);
        end else if (ac == bc) begin
            nar = step(ar, decrypt); nac = ac;
            nbr = step(br, decrypt); nbc = bc;
        end else begin
            nar = ar; nac = bc;
            nbr = br; nbc = ac;
        end
    end

    // Cell value select at the target positions
    always_comb
    begin
        va = '0;
        vb = '0;
        for (int r = 0; r < SIDE; r++) begin
            for (int c = 0; c < SIDE; c++) begin
                if (nar == 3'(r) && nac == 3'(c))
                    va = square[(r*SIDE+c)*CELL_W +: CELL_W];
                if (nbr == 3'(r) && nbc == 3'(c))
                    vb = square[(r*SIDE+c)*CELL_W +: CELL_W];
            end
        end
    end

    assign ra = (fa && fb) ? letter_of(va, is_upper(a)) : a;
    assign rb = (fa && fb) ? letter_of(vb, is_upper(b)) : b;

endmodule

// File: sv/pfc_out_stage.sv
// ----------------------------------------------------------------------------
// pfc_out_stage: result register pair
// Loads up to two result bytes; sends one beat per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module pfc_out_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  pfc_pkg::job_t job,
    input  logic [7:0]    ra,
    input  logic [7:0]    rb,
    output logic          job_take,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,   // [7:0] out_byte
    output logic          m_tlast
);
    import pfc_pkg::*;

    logic [1:0] cnt_reg, cnt_next;
    logic [7:0] b0_reg, b0_next;
    logic [7:0] b1_reg, b1_next;
    logic       pop;
    logic       free;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tlast  = (cnt_reg == 2'd1);
    assign m_tdata  = b0_reg;
    assign pop      = m_tvalid && m_tready;
    assign free     = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop);
    assign job_take = job.valid && free;

    // Load a new job or shift the next byte down
    always_comb
    begin
        cnt_next = cnt_reg;
        b0_next  = b0_reg;
        b1_next  = b1_reg;
        if (job_take) begin
            cnt_next = job.cnt;
            b0_next  = job.pair ? ra : job.b0;
            b1_next  = job.pair ? rb : job.b1;
        end else if (pop) begin
            cnt_next = cnt_reg - 2'd1;
            b0_next  = b1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        b0_reg <= b0_next;
        b1_reg <= b1_next;
    end

    ast_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result count out of range");

    ast_two_load: assert property (@(posedge clk) disable iff (!rst_n)
        (job_take && job.cnt == 2'd2) |=> (cnt_reg == 2'd2))
        else $error("two-beat job not loaded in full");

    ast_first_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && cnt_reg == 2'd2) |=> (cnt_reg == 2'd1 && b0_reg == $past(b1_reg)))
        else $error("second beat not moved down");

endmodule

// File: sv/playfair_digraph_stream_cipher_core.sv
// ----------------------------------------------------------------------------
// playfair_digraph_stream_cipher_core: Playfair 5x5 stream cipher top level
// Pairs letters of a byte stream and substitutes them through the key square.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one byte beat: tdata is the byte, tuser is the kind
//   (0 data, 1 end of stream). m_* returns result bytes; tlast marks the
//   final result caused by an input beat. Letters are held until paired,
//   so a beat may give zero, one or two results. cfg_ready is always high.
//   The user writes the mode (index 0) and the three key square words
//   (indexes 1..3) via cfg_* only while the block is idle (not enforced).
// Timing:
//   An accepted beat is held as a job in the input register; once the
//   result register is free, its substitution is loaded there and the
//   first result is offered from it. One input beat per cycle while
//   m_tready is high and each beat gives zero or one result; a beat that
//   gives two results holds the input longer, set by the single result
//   port.
//   When m_tready is low the results and the pending job hold and s_tready
//   drops once the job register is full.
// Reset: clears the pending letter and all queued results, selects encrypt
//   and loads the identity key square.
// ----------------------------------------------------------------------------
module playfair_digraph_stream_cipher_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] data_byte
    input  logic                       s_tuser,   // [0] kind
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,   // [7:0] out_byte
    output logic                       m_tlast,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [pfc_pkg::CFG_DW-1:0] cfg_data
);
    import pfc_pkg::*;

    logic             decrypt_reg;
    logic [SQ0_W-1:0] sq0_reg;
    logic [SQ1_W-1:0] sq1_reg;
    logic [SQ2_W-1:0] sq2_reg;
    job_t             job;
    logic             job_take;
    logic [7:0]       ra, rb;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            decrypt_reg <= 1'b0;
            sq0_reg     <= SQ0_RESET;
            sq1_reg     <= SQ1_RESET;
            sq2_reg     <= SQ2_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_MODE: decrypt_reg <= cfg_data[0];
                CFG_SQ0:  sq0_reg     <= cfg_data[SQ0_W-1:0];
                CFG_SQ1:  sq1_reg     <= cfg_data[SQ1_W-1:0];
                CFG_SQ2:  sq2_reg     <= cfg_data[SQ2_W-1:0];
                default:  ;
            endcase
        end
    end

    pfc_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .job_take (job_take),
        .job      (job)
    );

    pfc_pair_sub u_sub (
        .square  ({sq2_reg, sq1_reg, sq0_reg}),
        .decrypt (decrypt_reg),
        .a       (job.b0),
        .b       (job.b1),
        .ra      (ra),
        .rb      (rb)
    );

    pfc_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .job      (job),
        .ra       (ra),
        .rb       (rb),
        .job_take (job_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Input is only stalled while a job waits for the output stage
    ast_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (job.valid && !job_take))
        else $error("input stalled without a waiting job");

    // A job is taken only when the output side can accept it
    ast_take_room: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |-> (!m_tvalid || (m_tlast && m_tready)))
        else $error("job taken while results still queued");

    // Results only appear after a job was taken
    ast_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(job_take))
        else $error("result beat without a job");

endmodule

// File: tb/pfc_result_checker.sv
// ----------------------------------------------------------------------------
// pfc_result_checker: result predictor and comparator for the Playfair core
// Watches the input, result and configuration channels. Each accepted input
// beat is run through a local model of the digraph cipher. Each accepted
// result beat is compared with the oldest predicted byte.
// ----------------------------------------------------------------------------
module pfc_result_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] data_byte
    input  logic                       s_tuser,   // [0] kind
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [7:0]                 m_tdata,   // [7:0] out_byte
    input  logic                       m_tlast,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [pfc_pkg::CFG_DW-1:0] cfg_data,
    output int                         errors,
    output int                         outstanding,
    output int                         beats_checked
);
    import pfc_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } cipher_beat_t;

    // J-less alphabet, first letter in the top byte
    localparam logic [8*NCELLS-1:0] ALPHABET = "ABCDEFGHIKLMNOPQRSTUVWXYZ";

    // Local copy of the registers and the pairing state
    logic             mode_dec;
    logic [SQ0_W-1:0] sq_a;
    logic [SQ1_W-1:0] sq_b;
    logic [SQ2_W-1:0] sq_c;
    logic             held_v;
    logic [7:0]       held_ch;
    cipher_beat_t     awaited_bytes[$];
    cipher_beat_t     oldest;

    function automatic logic [CELL_W-1:0] cell_val(input int n);
        if (n < 9)
            return sq_a[CELL_W*n +: CELL_W];
        else if (n < 17)
            return sq_b[CELL_W*(n-9) +: CELL_W];
        return sq_c[CELL_W*(n-17) +: CELL_W];
    endfunction

    function automatic logic upper_ch(input logic [7:0] c);
        return (c >= CH_UA) && (c <= CH_UZ);
    endfunction

    function automatic logic letter_ch(input logic [7:0] c);
        return upper_ch(c) || ((c >= CH_LA) && (c <= CH_LZ));
    endfunction

    // Position in the J-less alphabet, J counted as I
    function automatic logic [CELL_W-1:0] alpha_pos(input logic [7:0] c);
        logic [7:0] u;
        u = upper_ch(c) ? c : c - CASE_OFS;
        if (u == CH_UJ)
            u = CH_UI;
        u = (u < CH_UJ) ? u - CH_UA : u - CH_UA - 8'd1;
        return u[CELL_W-1:0];
    endfunction

    // Lowest cell holding the letter; NCELLS when the letter is absent
    function automatic int find_cell(input logic [7:0] c);
        logic [CELL_W-1:0] want;
        want = alpha_pos(c);
        for (int n = 0; n < NCELLS; n++)
            if (cell_val(n) == want)
                return n;
        return NCELLS;
    endfunction

    // Letter of a cell; values past the alphabet read as Z
    function automatic logic [7:0] glyph_at(input int n, input logic up);
        logic [CELL_W-1:0] v;
        logic [7:0]        ch;
        v  = cell_val(n);
        ch = (v < NCELLS) ? ALPHABET[8*(NCELLS-1-int'(v)) +: 8] : CH_UZ;
        return up ? ch : ch + CASE_OFS;
    endfunction

    task automatic push_beat(input logic [7:0] b, input logic l);
        cipher_beat_t e;
        e.out_byte = b;
        e.last     = l;
        awaited_bytes.push_back(e);
    endtask

    task automatic substitute_pair(input logic [7:0] a, input logic [7:0] b,
                                   output logic [7:0] ra, output logic [7:0] rb);
        int pa, pb, ar, ac, br, bc, na, nb, step;
        pa   = find_cell(a);
        pb   = find_cell(b);
        step = mode_dec ? SIDE - 1 : 1;
        if (pa >= NCELLS || pb >= NCELLS)
        begin
            // a letter missing from the square leaves the pair untouched
            ra = a;
            rb = b;
        end
        else
        begin
            ar = pa / SIDE;
            ac = pa % SIDE;
            br = pb / SIDE;
            bc = pb % SIDE;
            if (ar == br)
            begin
                na = ar * SIDE + (ac + step) % SIDE;
                nb = br * SIDE + (bc + step) % SIDE;
            end
            else if (ac == bc)
            begin
                na = ((ar + step) % SIDE) * SIDE + ac;
                nb = ((br + step) % SIDE) * SIDE + bc;
            end
            else
            begin
                na = ar * SIDE + bc;
                nb = br * SIDE + ac;
            end
            ra = glyph_at(na, upper_ch(a));
            rb = glyph_at(nb, upper_ch(b));
        end
    endtask

    // Predict the result bytes caused by one input beat
    task automatic encipher_beat(input logic k, input logic [7:0] d);
        logic [7:0] c, r0, r1;
        if (k == KIND_EOS)
        begin
            if (held_v)
                push_beat(held_ch, 1'b1);
            held_v = 1'b0;
        end
        else if (!letter_ch(d))
        begin
            // non-letter flushes the waiting letter, then passes through
            if (held_v)
                push_beat(held_ch, 1'b0);
            held_v = 1'b0;
            push_beat(d, 1'b1);
        end
        else
        begin
            c = (d == CH_UJ) ? CH_UI : (d == CH_LJ) ? CH_LI : d;
            if (!held_v)
            begin
                held_ch = c;
                held_v  = 1'b1;
            end
            else
            begin
                substitute_pair(held_ch, c, r0, r1);
                push_beat(r0, 1'b0);
                push_beat(r1, 1'b1);
                held_v = 1'b0;
            end
        end
    endtask

    // Channel monitor: results are checked before the new beat is predicted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_dec = 1'b0;
            sq_a     = SQ0_RESET;
            sq_b     = SQ1_RESET;
            sq_c     = SQ2_RESET;
            held_v   = 1'b0;
            held_ch  = 8'd0;
            awaited_bytes.delete();
            errors        = 0;
            beats_checked = 0;
            outstanding  <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (awaited_bytes.size() == 0)
                begin
                    $error("out_byte: expected no result, actual 8'h%02h", m_tdata);
                    errors++;
                end
                else
                begin
                    oldest = awaited_bytes.pop_front();
                    beats_checked++;
                    if (m_tdata !== oldest.out_byte)
                    begin
                        $error("out_byte: expected 8'h%02h, actual 8'h%02h",
                               oldest.out_byte, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== oldest.last)
                    begin
                        $error("last: expected %0d, actual %0d", oldest.last, m_tlast);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MODE: mode_dec = cfg_data[0];
                    CFG_SQ0:  sq_a     = cfg_data[SQ0_W-1:0];
                    CFG_SQ1:  sq_b     = cfg_data[SQ1_W-1:0];
                    CFG_SQ2:  sq_c     = cfg_data[SQ2_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                encipher_beat(s_tuser, s_tdata);
            outstanding <= awaited_bytes.size();
        end
    end

endmodule

// File: tb/playfair_digraph_stream_cipher_core_test.sv
// ----------------------------------------------------------------------------
// playfair_digraph_stream_cipher_core_test: regression for the Playfair core
// Directed letter pairs and boundary bytes, then random streams over several
// key squares and both modes, with bursty input and a stalling result side.
// ----------------------------------------------------------------------------
module playfair_digraph_stream_cipher_core_test;
    import pfc_pkg::*;

    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 100;
    localparam int SETTLE      = 6;
    localparam int STALL_LIMIT = 2000;

    typedef enum int {
        SQ_IDENTITY,
        SQ_REVERSED,
        SQ_SHUFFLED,
        SQ_FAULTY,
        SQ_RAW,
        SQ_ZERO,
        SQ_ONES
    } square_style_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [7:0]        s_tdata;   // [7:0] data_byte
    logic              s_tuser;   // [0] kind
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;   // [7:0] out_byte
    logic              m_tlast;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [1:0]        cfg_index;
    logic [CFG_DW-1:0] cfg_data;

    int                errors;
    int                outstanding;
    int                beats_checked;
    int                items_sent;
    int                burst_left;
    int                stall_left = 0;
    int                idle_cycles = 0;
    logic              rdy_state = 1'b0;
    logic              gaps_on;
    logic              stalls_on = 1'b1;
    logic [CELL_W-1:0] sq_cells [0:NCELLS-1];

    always #6 clk = ~clk;

    playfair_digraph_stream_cipher_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pfc_result_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .outstanding   (outstanding),
        .beats_checked (beats_checked)
    );

    // Result side: alternating ready and stall runs of random length
    always @(posedge clk)
    begin
        if (!stalls_on)
            m_tready <= 1'b1;
        else
        begin
            if (stall_left == 0)
            begin
                rdy_state  = !rdy_state;
                stall_left = rdy_state ? $urandom_range(1, 12) : $urandom_range(1, 8);
            end
            stall_left--;
            m_tready <= rdy_state;
        end
    end

    // Watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("playfair_digraph_stream_cipher_core regression: fail");
            $finish;
        end
    end

    // One input beat; bursts of random length with random gaps between them
    task automatic send_beat(input logic k, input logic [7:0] d);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= d;
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_beat(KIND_DATA, txt[i]);
    endtask

    // Mostly letters so that pairs form; the rest raw bytes and end markers
    task automatic send_random();
        int         r;
        logic [7:0] d;
        r = $urandom_range(0, 99);
        d = 8'($urandom);
        if (r < 72)
        begin
            d = ($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'($urandom_range(0, 25));
            send_beat(KIND_DATA, d);
        end
        else if (r < 88)
            send_beat(KIND_DATA, d);
        else
            send_beat(KIND_EOS, d);
    endtask

    // Stop sending and let every predicted result drain
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Build a key square and write all three square words
    task automatic set_square(input square_style_t style);
        logic [CFG_DW-1:0] w0, w1, w2;
        logic [CELL_W-1:0] t;
        int                j;
        for (int k = 0; k < NCELLS; k++)
            sq_cells[k] = (style == SQ_REVERSED) ? CELL_W'(NCELLS - 1 - k) :
                          (style == SQ_ZERO)     ? '0 :
                          (style == SQ_ONES)     ? '1 : CELL_W'(k);
        if (style == SQ_SHUFFLED || style == SQ_FAULTY)
        begin
            for (int k = NCELLS - 1; k > 0; k--)
            begin
                j           = $urandom_range(0, k);
                t           = sq_cells[k];
                sq_cells[k] = sq_cells[j];
                sq_cells[j] = t;
            end
        end
        // duplicates, missing letters and out-of-range cells
        if (style == SQ_FAULTY)
            repeat ($urandom_range(1, 4))
                sq_cells[$urandom_range(0, NCELLS - 1)] = CELL_W'($urandom_range(0, 31));
        // unused upper bits of the narrower words stay random
        w0 = CFG_DW'({$urandom, $urandom});
        w1 = CFG_DW'({$urandom, $urandom});
        w2 = CFG_DW'({$urandom, $urandom});
        if (style != SQ_RAW)
        begin
            for (int k = 0; k < NCELLS; k++)
            begin
                if (k < 9)
                    w0[CELL_W*k +: CELL_W] = sq_cells[k];
                else if (k < 17)
                    w1[CELL_W*(k-9) +: CELL_W] = sq_cells[k];
                else
                    w2[CELL_W*(k-17) +: CELL_W] = sq_cells[k];
            end
        end
        write_reg(CFG_SQ0, w0);
        write_reg(CFG_SQ1, w1);
        write_reg(CFG_SQ2, w2);
    endtask

    // Stimulus and verdict
    initial
    begin
        square_style_t     style;
        logic              mode;
        logic [CFG_DW-1:0] mode_word;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'd0;
        s_tuser    = KIND_DATA;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_MODE;
        cfg_data   = '0;
        gaps_on    = 1'b1;
        burst_left = 0;
        items_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: same row with wrap, same column with wrap, rectangle,
        // J folding, mixed case, doubled letter, flushes and byte limits
        send_text("ABAFEAVAaGJkLLQ!");
        send_beat(KIND_DATA, 8'h00);
        send_beat(KIND_DATA, 8'hFF);
        send_beat(KIND_DATA, CH_LZ);
        send_beat(KIND_EOS, 8'hA5);
        send_beat(KIND_EOS, 8'h5A);
        send_text("Z@[`{");
        wait_quiet();

        // Random streams, one key square and mode per phase
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin style = SQ_IDENTITY; mode = 1'b1; end
                1: begin style = SQ_SHUFFLED; mode = 1'b0; end
                2: begin style = SQ_SHUFFLED; mode = 1'b1; end
                3: begin style = SQ_REVERSED; mode = 1'b0; end
                4: begin style = SQ_FAULTY;   mode = 1'b1; end
                5: begin style = SQ_RAW;      mode = 1'b0; end
                6: begin style = SQ_ZERO;     mode = 1'b1; end
                7: begin style = SQ_ONES;     mode = 1'b0; end
                default: begin style = SQ_FAULTY; mode = 1'b0; end
            endcase
            // phase 1 runs with no idling on either side
            gaps_on      = (p != 1) && ($urandom_range(0, 3) != 0);
            stalls_on    = (p != 1) && ($urandom_range(0, 3) != 0);
            mode_word    = CFG_DW'({$urandom, $urandom});
            mode_word[0] = mode;
            write_reg(CFG_MODE, mode_word);
            set_square(style);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 4 && i == PHASE_ITEMS / 2)
                    wait_quiet();
                send_random();
            end
            wait_quiet();
        end

        $display("Sent %0d input beats and checked %0d result beats", items_sent,
                 beats_checked);
        $display("over %0d key squares in both modes, with and without back-pressure.",
                 PHASES + 1);
        if (errors == 0 && outstanding == 0)
            $display("playfair_digraph_stream_cipher_core regression: pass");
        else
            $display("playfair_digraph_stream_cipher_core regression: fail");
        $finish;
    end

endmodule
